[hw/rtl/cca_pkg.sv]
// Shared types, constants and calendar helpers for the calendar clock core.
`timescale 1ns / 1ps
`default_nettype none

package cca_pkg;

    // Event command codes
    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_ROTARY    = 3'd1,
        CMD_EDIT      = 3'd2,
        CMD_SNOOZE    = 3'd3,
        CMD_SET_TIME  = 3'd4,
        CMD_SET_ALARM = 3'd5
    } t_cmd;

    // Edit mode codes
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_EDIT_HR  = 2'd1,
        MODE_EDIT_MIN = 2'd2
    } t_mode;

    // Screen redraw request codes
    typedef enum logic [1:0] {
        SCREEN_NONE = 2'd0,
        SCREEN_EDIT = 2'd1,
        SCREEN_HOME = 2'd2
    } t_screen;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LEAP_Q,
        ST_LEAP_R,
        ST_CLAMP,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Calendar limits and reset values
    localparam logic [5:0]  SEC_LAST   = 6'd59;
    localparam logic [5:0]  MIN_LAST   = 6'd59;
    localparam logic [4:0]  HOUR_LAST  = 5'd23;
    localparam logic [4:0]  SYNC_HOUR  = 5'd3;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [13:0] YEAR_LAST  = 14'd9999;
    localparam logic [13:0] YEAR_RESET = 14'd2000;

    // Year / 100 by reciprocal: exact for every 14-bit year
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;
    localparam int          QUOT_W      = 8;
    localparam logic [6:0]  CENTURY     = 7'd100;

    // One event beat
    typedef struct packed {
        logic [2:0]  command;
        logic        clockwise;
        logic [5:0]  second_value;
        logic [5:0]  minute_value;
        logic [4:0]  hour_value;
        logic [4:0]  day_value;
        logic [3:0]  month_value;
        logic [13:0] year_value;
        logic [1:0]  alarm_index;
        logic        active_flag;
        logic        repeat_flag;
    } t_event;

    // One result beat
    typedef struct packed {
        logic [5:0]  cur_second;
        logic [5:0]  cur_minute;
        logic [4:0]  cur_hour;
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [13:0] cur_year;
        logic [1:0]  edit_mode;
        logic        alarm_ringing;
        logic        minute_rollover;
        logic        time_sync_request;
        logic [1:0]  screen_request;
        logic [5:0]  edited_value;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic leap_q;
        logic leap_r;
        logic clamp;
        logic scan_step;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_leap;
        logic need_scan;
        logic scan_pend;
        logic scan_last;
        logic out_busy;
    } t_dp_sts;

    // Days in a month, given the leap flag of its year
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month) inside
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/cca_in_if.sv]
// Event channel: valid/ready handshake with the event fields.
`timescale 1ns / 1ps
`default_nettype none

interface cca_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic        clockwise;
    logic [5:0]  second_value;
    logic [5:0]  minute_value;
    logic [4:0]  hour_value;
    logic [4:0]  day_value;
    logic [3:0]  month_value;
    logic [13:0] year_value;
    logic [1:0]  alarm_index;
    logic        active_flag;
    logic        repeat_flag;

    modport source (
        output valid, command, clockwise, second_value, minute_value, hour_value,
               day_value, month_value, year_value, alarm_index, active_flag, repeat_flag,
        input  ready
    );

    modport sink (
        input  valid, command, clockwise, second_value, minute_value, hour_value,
               day_value, month_value, year_value, alarm_index, active_flag, repeat_flag,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/cca_out_if.sv]
// Result channel: valid/ready handshake with the result fields.
`timescale 1ns / 1ps
`default_nettype none

interface cca_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  cur_second;
    logic [5:0]  cur_minute;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [13:0] cur_year;
    logic [1:0]  edit_mode;
    logic        alarm_ringing;
    logic        minute_rollover;
    logic        time_sync_request;
    logic [1:0]  screen_request;
    logic [5:0]  edited_value;

    modport source (
        output valid, cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
               edit_mode, alarm_ringing, minute_rollover, time_sync_request,
               screen_request, edited_value,
        input  ready
    );

    modport sink (
        input  valid, cur_second, cur_minute, cur_hour, cur_day, cur_month, cur_year,
               edit_mode, alarm_ringing, minute_rollover, time_sync_request,
               screen_request, edited_value,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/calendar_clock_with_alarms_core.sv]
// Calendar clock with alarm table: top level joining the sequencer and the datapath.
// Each event beat is captured, executed and loaded into the result register; additionally,
// a tick that wraps the seconds in normal mode scans the alarm table, one alarm entry per
// cycle, and a time write or a year change runs the leap-year quotient, leap flag and day
// clamp steps. One event at a time; a stalled result holds off the next event.
// Reset (synchronous, active low): 00:00:00 on 1 January 2000, normal mode, all alarms clear.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_with_alarms_core
    import cca_pkg::*;
#(
    parameter int ALARM_COUNT = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cca_in_if.sink    i_ev,
    cca_out_if.source o_res
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;
    t_event  s_ev;
    t_result s_res;
    logic    s_res_valid;
    logic    s_in_ready;

    // Pack the event beat
    always_comb begin
        s_ev.command      = i_ev.command;
        s_ev.clockwise    = i_ev.clockwise;
        s_ev.second_value = i_ev.second_value;
        s_ev.minute_value = i_ev.minute_value;
        s_ev.hour_value   = i_ev.hour_value;
        s_ev.day_value    = i_ev.day_value;
        s_ev.month_value  = i_ev.month_value;
        s_ev.year_value   = i_ev.year_value;
        s_ev.alarm_index  = i_ev.alarm_index;
        s_ev.active_flag  = i_ev.active_flag;
        s_ev.repeat_flag  = i_ev.repeat_flag;
    end

    assign i_ev.ready = s_in_ready;

    cca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_ev.valid),
        .o_in_ready (s_in_ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    cca_dp #(
        .ALARM_COUNT (ALARM_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_ev        (s_ev),
        .o_res       (s_res),
        .o_res_valid (s_res_valid),
        .i_res_ready (o_res.ready)
    );

    // Unpack the result beat
    always_comb begin
        o_res.valid             = s_res_valid;
        o_res.cur_second        = s_res.cur_second;
        o_res.cur_minute        = s_res.cur_minute;
        o_res.cur_hour          = s_res.cur_hour;
        o_res.cur_day           = s_res.cur_day;
        o_res.cur_month         = s_res.cur_month;
        o_res.cur_year          = s_res.cur_year;
        o_res.edit_mode         = s_res.edit_mode;
        o_res.alarm_ringing     = s_res.alarm_ringing;
        o_res.minute_rollover   = s_res.minute_rollover;
        o_res.time_sync_request = s_res.time_sync_request;
        o_res.screen_request    = s_res.screen_request;
        o_res.edited_value      = s_res.edited_value;
    end

`ifndef SYNTHESIS
    // One event in flight: ready drops right after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ev.valid && i_ev.ready) |=> !i_ev.ready)
        else $error("event accepted while another is in flight");

    // Never overwrite a result beat that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |-> !s_sts.out_busy)
        else $error("result register overwritten");

    // Shown time of day stays in range
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.cur_second <= SEC_LAST) && (o_res.cur_minute <= MIN_LAST) &&
                        (o_res.cur_hour <= HOUR_LAST))
        else $error("time of day out of range");

    // Sync pulse only at the sync time, which a tick reaches by wrapping the seconds
    a_sync_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.time_sync_request) |->
            (o_res.cur_hour == SYNC_HOUR) && (o_res.cur_minute == 6'd0) &&
            (o_res.cur_second == 6'd0) && o_res.minute_rollover)
        else $error("sync pulse away from the sync time");
`endif

endmodule

`default_nettype wire

[hw/rtl/cca_ctrl.sv]
// Sequencer for one event: execute, leap-year update, day clamp, alarm scan, result load.
`timescale 1ns / 1ps
`default_nettype none

module cca_ctrl
    import cca_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the next step and drive the datapath
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_leap) begin
                    n_state = ST_LEAP_Q;
                end else if (i_sts.need_scan) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LEAP_Q: begin
                o_cmd.leap_q = 1'b1;
                n_state      = ST_LEAP_R;
            end
            ST_LEAP_R: begin
                o_cmd.leap_r = 1'b1;
                n_state      = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = i_sts.scan_pend ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/cca_dp.sv]
// Calendar, mode and alarm table datapath with the result register.
`timescale 1ns / 1ps
`default_nettype none

module cca_dp
    import cca_pkg::*;
#(
    parameter int ALARM_COUNT = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    input  wire t_event  i_ev,
    output t_result      o_res,
    output logic         o_res_valid,
    input  wire logic    i_res_ready
);

    localparam int IDX_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;

    // Captured event
    t_event r_ev;

    // Calendar and mode state
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic        r_leap;
    t_mode       r_mode;
    logic        r_ringing;

    // Per-event flags
    logic        r_roll;
    logic        r_sync;
    t_screen     r_screen;
    logic        r_scan_pend;

    // Leap-year and scan helpers
    logic [QUOT_W-1:0] r_quot;
    logic [IDX_W-1:0]  r_scan;

    // Alarm table
    logic [4:0] r_al_hour [ALARM_COUNT];
    logic [5:0] r_al_min  [ALARM_COUNT];
    logic       r_al_en   [ALARM_COUNT];
    logic       r_al_rep  [ALARM_COUNT];

    // Result register
    t_result r_out;
    logic    r_out_valid;

    // Tick carry chain
    logic        w_sec_wrap;
    logic        w_c_hour;
    logic        w_c_day;
    logic        w_c_mon;
    logic        w_c_year;
    logic [5:0]  w_t_sec;
    logic [5:0]  w_t_min;
    logic [4:0]  w_t_hour;
    logic [4:0]  w_t_day;
    logic [3:0]  w_t_month;
    logic [13:0] w_t_year;
    logic        w_t_sync;

    // Set-time clamps
    logic [5:0]  w_s_sec;
    logic [5:0]  w_s_min;
    logic [4:0]  w_s_hour;
    logic [4:0]  w_s_day;
    logic [3:0]  w_s_month;
    logic [13:0] w_s_year;

    // Leap and clamp helpers
    logic [26:0] w_prod;
    logic [14:0] w_cent;
    logic        w_leap;
    logic [4:0]  w_len;

    // Alarm write and scan helpers
    logic [4:0]       w_widx;
    logic             w_wok;
    logic [IDX_W-1:0] w_wa;
    logic             w_hit;
    logic [5:0]       w_edited;

    // Advance the time by one second
    always_comb begin
        w_sec_wrap = (r_sec >= SEC_LAST);
        w_c_hour   = w_sec_wrap && (r_min >= MIN_LAST);
        w_c_day    = w_c_hour && (r_hour >= HOUR_LAST);
        w_c_mon    = w_c_day && (r_day >= month_len(r_month, r_leap));
        w_c_year   = w_c_mon && (r_month >= MONTH_LAST);
        w_t_sec    = w_sec_wrap ? 6'd0 : r_sec + 6'd1;
        w_t_min    = r_min;
        if (w_sec_wrap) begin
            w_t_min = (r_min >= MIN_LAST) ? 6'd0 : r_min + 6'd1;
        end
        w_t_hour = r_hour;
        if (w_c_hour) begin
            w_t_hour = (r_hour >= HOUR_LAST) ? 5'd0 : r_hour + 5'd1;
        end
        w_t_day = r_day;
        if (w_c_day) begin
            w_t_day = w_c_mon ? DAY_FIRST : r_day + 5'd1;
        end
        w_t_month = r_month;
        if (w_c_mon) begin
            w_t_month = w_c_year ? MONTH_FIRST : r_month + 4'd1;
        end
        w_t_year = r_year;
        if (w_c_year) begin
            w_t_year = (r_year >= YEAR_LAST) ? 14'd0 : r_year + 14'd1;
        end
        w_t_sync = (w_t_hour == SYNC_HOUR) && (w_t_min == 6'd0) && (w_t_sec == 6'd0);
    end

    // Clamp a written time; the day upper bound waits for the leap flag
    always_comb begin
        w_s_sec   = (r_ev.second_value > SEC_LAST) ? SEC_LAST : r_ev.second_value;
        w_s_min   = (r_ev.minute_value > MIN_LAST) ? MIN_LAST : r_ev.minute_value;
        w_s_hour  = (r_ev.hour_value > HOUR_LAST) ? HOUR_LAST : r_ev.hour_value;
        w_s_day   = (r_ev.day_value == 5'd0) ? DAY_FIRST : r_ev.day_value;
        w_s_month = r_ev.month_value;
        if (r_ev.month_value == 4'd0) begin
            w_s_month = MONTH_FIRST;
        end else if (r_ev.month_value > MONTH_LAST) begin
            w_s_month = MONTH_LAST;
        end
        w_s_year = (r_ev.year_value > YEAR_LAST) ? YEAR_LAST : r_ev.year_value;
    end

    // Leap test: divisible by 4, and not a century unless the century count is too
    assign w_prod = 27'(r_year) * 27'(RECIP_100);
    assign w_cent = 15'(r_quot) * 15'(CENTURY);
    assign w_leap = (r_year[1:0] == 2'd0) &&
                    ((15'(r_year) != w_cent) || (r_quot[1:0] == 2'd0));
    assign w_len  = month_len(r_month, r_leap);

    // Alarm write address and scan match
    assign w_widx = 5'(r_ev.alarm_index);
    assign w_wok  = (w_widx < 5'(ALARM_COUNT));
    assign w_wa   = w_widx[IDX_W-1:0];
    assign w_hit  = r_al_en[r_scan] && (r_al_hour[r_scan] == r_hour) &&
                    (r_al_min[r_scan] == r_min);

    // Alarm 0 field under edit
    always_comb begin
        case (r_mode)
            MODE_EDIT_HR:  w_edited = 6'(r_al_hour[0]);
            MODE_EDIT_MIN: w_edited = r_al_min[0];
            default:       w_edited = 6'd0;
        endcase
    end

    // Report status to the controller
    always_comb begin
        o_sts.need_leap = (r_ev.command == CMD_SET_TIME) ||
                          ((r_ev.command == CMD_TICK) && w_c_year);
        o_sts.need_scan = (r_ev.command == CMD_TICK) && (r_mode == MODE_NORMAL) && w_sec_wrap;
        o_sts.scan_pend = r_scan_pend;
        o_sts.scan_last = (r_scan == IDX_W'(ALARM_COUNT - 1));
        o_sts.out_busy  = r_out_valid && !i_res_ready;
    end

    // Capture the event beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ev <= i_ev;
        end
    end

    // Hold the leap-year quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.leap_q) begin
            r_quot <= w_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    // Update calendar, mode, flags and the alarm table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= 6'd0;
            r_min       <= 6'd0;
            r_hour      <= 5'd0;
            r_day       <= DAY_FIRST;
            r_month     <= MONTH_FIRST;
            r_year      <= YEAR_RESET;
            r_leap      <= 1'b1;
            r_mode      <= MODE_NORMAL;
            r_ringing   <= 1'b0;
            r_roll      <= 1'b0;
            r_sync      <= 1'b0;
            r_screen    <= SCREEN_NONE;
            r_scan_pend <= 1'b0;
            r_scan      <= '0;
            for (int i = 0; i < ALARM_COUNT; i++) begin
                r_al_hour[i] <= 5'd0;
                r_al_min[i]  <= 6'd0;
                r_al_en[i]   <= 1'b0;
                r_al_rep[i]  <= 1'b0;
            end
        end else if (i_cmd.capture) begin
            r_roll      <= 1'b0;
            r_sync      <= 1'b0;
            r_screen    <= SCREEN_NONE;
            r_scan_pend <= 1'b0;
            r_scan      <= '0;
        end else if (i_cmd.exec) begin
            r_scan_pend <= o_sts.need_scan;
            unique case (r_ev.command)
                CMD_TICK: begin
                    r_sec   <= w_t_sec;
                    r_min   <= w_t_min;
                    r_hour  <= w_t_hour;
                    r_day   <= w_t_day;
                    r_month <= w_t_month;
                    r_year  <= w_t_year;
                    r_roll  <= w_sec_wrap;
                    r_sync  <= w_t_sync;
                end
                CMD_ROTARY: begin
                    if (r_mode != MODE_NORMAL) begin
                        if (r_mode == MODE_EDIT_HR) begin
                            if (r_ev.clockwise) begin
                                r_al_hour[0] <= (r_al_hour[0] >= HOUR_LAST) ? 5'd0
                                                                             : r_al_hour[0] + 5'd1;
                            end else begin
                                r_al_hour[0] <= (r_al_hour[0] == 5'd0) ? HOUR_LAST
                                                                        : r_al_hour[0] - 5'd1;
                            end
                        end else if (r_mode == MODE_EDIT_MIN) begin
                            if (r_ev.clockwise) begin
                                r_al_min[0] <= (r_al_min[0] >= MIN_LAST) ? 6'd0
                                                                          : r_al_min[0] + 6'd1;
                            end else begin
                                r_al_min[0] <= (r_al_min[0] == 6'd0) ? MIN_LAST
                                                                      : r_al_min[0] - 6'd1;
                            end
                        end
                        r_al_en[0] <= 1'b1;
                        r_screen   <= SCREEN_EDIT;
                    end
                end
                CMD_EDIT: begin
                    case (r_mode)
                        MODE_NORMAL: begin
                            r_mode   <= MODE_EDIT_HR;
                            r_screen <= SCREEN_EDIT;
                        end
                        MODE_EDIT_HR: begin
                            r_mode   <= MODE_EDIT_MIN;
                            r_screen <= SCREEN_EDIT;
                        end
                        default: begin
                            r_mode   <= MODE_NORMAL;
                            r_screen <= SCREEN_HOME;
                        end
                    endcase
                end
                CMD_SNOOZE: begin
                    if (r_mode == MODE_NORMAL) begin
                        if (r_ringing) begin
                            r_ringing  <= 1'b0;
                            r_al_en[0] <= r_al_rep[0];
                        end else begin
                            r_al_en[0] <= !r_al_en[0];
                        end
                        r_screen <= SCREEN_HOME;
                    end else begin
                        r_al_rep[0] <= !r_al_rep[0];
                        r_screen    <= SCREEN_EDIT;
                    end
                end
                CMD_SET_TIME: begin
                    r_sec   <= w_s_sec;
                    r_min   <= w_s_min;
                    r_hour  <= w_s_hour;
                    r_day   <= w_s_day;
                    r_month <= w_s_month;
                    r_year  <= w_s_year;
                end
                CMD_SET_ALARM: begin
                    if (w_wok) begin
                        r_al_min[w_wa]  <= (r_ev.minute_value > MIN_LAST) ? MIN_LAST
                                                                           : r_ev.minute_value;
                        r_al_hour[w_wa] <= (r_ev.hour_value > HOUR_LAST) ? HOUR_LAST
                                                                          : r_ev.hour_value;
                        r_al_en[w_wa]   <= r_ev.active_flag;
                        r_al_rep[w_wa]  <= r_ev.repeat_flag;
                    end
                end
                default: begin
                    // unused command codes leave everything alone
                end
            endcase
        end else if (i_cmd.leap_r) begin
            r_leap <= w_leap;
        end else if (i_cmd.clamp) begin
            if (r_day > w_len) begin
                r_day <= w_len;
            end
        end else if (i_cmd.scan_step) begin
            if (w_hit) begin
                r_ringing <= 1'b1;
                if (!r_al_rep[r_scan]) begin
                    r_al_en[r_scan] <= 1'b0;
                end
            end
            r_scan <= r_scan + IDX_W'(1);
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.cur_second        <= r_sec;
            r_out.cur_minute        <= r_min;
            r_out.cur_hour          <= r_hour;
            r_out.cur_day           <= r_day;
            r_out.cur_month         <= r_month;
            r_out.cur_year          <= r_year;
            r_out.edit_mode         <= r_mode;
            r_out.alarm_ringing     <= r_ringing;
            r_out.minute_rollover   <= r_roll;
            r_out.time_sync_request <= r_sync;
            r_out.screen_request    <= r_screen;
            r_out.edited_value      <= w_edited;
        end
    end

    // Track the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

`default_nettype wire
